/* sv/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// Life generation stencil package
// Shared constants, register codes, the per-beat control struct and the
// B3/S23 update rule.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int WIDTH_RESET  = 80;
    localparam int HEIGHT_RESET = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic REQ_CELL = 1'b0;
    localparam logic REQ_PAD  = 1'b1;

    localparam logic [8:0] NEIGHBOR_MASK = 9'h1EF;

    typedef struct packed {
        logic alive;
        logic above_ok;
        logic two_ok;
        logic col0;
        logic last;
    } t_pos_info;

    // Window bit 3*col+row; the center cell is bit 4.
    function automatic logic life_rule(input logic [8:0] win);
        logic [8:0] nb;
        logic [3:0] count;
        nb    = win & NEIGHBOR_MASK;
        count = '0;
        for (int i = 0; i < 9; i++) begin
            count = count + {3'b000, nb[i]};
        end
        return (count == 4'd3) || (win[4] && (count == 4'd2));
    endfunction

endpackage

/* sv/lgs_line_store.sv */
// ----------------------------------------------------------------------------
// Life generation stencil line store
// Holds the two rows above the current one, two bits per column. The read
// is registered; a write to the address being read forwards its data.
// ----------------------------------------------------------------------------
module lgs_line_store #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [1:0]               i_wr_data,
    output logic [1:0]               o_rd_data
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* sv/lgs_position.sv */
// ----------------------------------------------------------------------------
// Life generation stencil position tracker
// Holds the grid size registers and the raster position of the next beat,
// and classifies each accepted beat against the grid bounds.
// ----------------------------------------------------------------------------
module lgs_position #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                         i_advance,
    input  logic                         i_req_type,
    input  logic                         i_cell_alive,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output lgs_pkg::t_pos_info           o_info
);

    import lgs_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int RST_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WID_W-1:0] r_w;
    logic [HGT_W-1:0] r_h;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [31:0]      cfg_wide;
    logic [31:0]      clamp_w;
    logic [31:0]      clamp_h;
    logic             col_wrap;

    always_comb begin
        cfg_wide = 32'(i_cfg_wr_data);
        if (cfg_wide == 32'd0) begin
            clamp_w = 32'd1;
            clamp_h = 32'd1;
        end else begin
            clamp_w = (cfg_wide > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_wide;
            clamp_h = (cfg_wide > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_wide;
        end
    end

    always_comb begin
        o_info.alive    = (i_req_type == REQ_CELL) && i_cell_alive &&
                          (32'(r_row) < 32'(r_h));
        o_info.above_ok = (r_row != '0);
        o_info.two_ok   = (32'(r_row) >= 32'd2);
        o_info.col0     = (r_col == '0);
        o_info.last     = (32'(r_row) == (32'(r_h) + 32'd1));
        col_wrap        = ((32'(r_col) + 32'd1) >= 32'(r_w));
        if (o_info.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_wrap) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WID_W'(RST_W);
            r_h   <= HGT_W'(RST_H);
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH:  r_w <= WID_W'(clamp_w);
                REG_GRID_HEIGHT: r_h <= HGT_W'(clamp_h);
                default:         ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;

endmodule

/* sv/life_generation_stencil.sv */
// ----------------------------------------------------------------------------
// Life generation stencil
// One B3/S23 generation over a configurable bounded grid, streamed in raster
// order with a row-plus-one-cell flush of padding beats after each frame.
//
//   channel   direction  handshake                beat
//   in        sink       i_in_valid / o_in_ready  i_req_type, i_cell_alive
//   out       source     o_out_valid / i_out_ready o_next_alive, o_row_end,
//                                                 o_frame_end
//   cfg       sink       i_cfg_wr_en              i_cfg_index, i_cfg_wr_data
//
// One beat is accepted per cycle while o_in_ready is high; each accepted beat
// is registered in stage one along with its registered line store read, and
// its result then goes to the output register. The input side keeps
// accepting while a result waits, and stalls only when both the output register
// and the stage behind it are full and the output is not taken.
// Reset is synchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module life_generation_stencil #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic                          i_cell_alive,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_next_alive,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_wr_en,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     i_cfg_wr_data
);

    import lgs_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0] pos_col;
    t_pos_info        pos_info;
    logic             in_accept;

    logic             r_s1_valid;
    t_pos_info        r_s1_info;
    logic [COL_W-1:0] r_s1_col;
    logic [1:0]       rd_data;

    logic [8:0]       r_win, n_win;
    logic             r_out_valid;
    logic             r_next_alive, r_row_end, r_frame_end;
    logic             n_has_out, n_next_alive, n_row_end, n_frame_end;

    logic             out_free;
    logic             fire;
    logic [2:0]       newcol;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    lgs_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (in_accept),
        .i_req_type    (i_req_type),
        .i_cell_alive  (i_cell_alive),
        .o_col         (pos_col),
        .o_info        (pos_info)
    );

    lgs_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (pos_col),
        .i_wr_en   (fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[0], r_s1_info.alive}),
        .o_rd_data (rd_data)
    );

    always_comb begin
        newcol = {r_s1_info.alive,
                  r_s1_info.above_ok & rd_data[0],
                  r_s1_info.two_ok & rd_data[1]};
        if (r_s1_info.col0) begin
            // The previous row's last cell is finished with a dead right column.
            n_has_out    = r_s1_info.two_ok;
            n_next_alive = life_rule({3'b000, r_win[8:3]});
            n_row_end    = 1'b1;
            n_frame_end  = r_s1_info.last;
            n_win        = {newcol, 6'b000000};
        end else begin
            n_win        = {newcol, r_win[8:3]};
            n_has_out    = r_s1_info.above_ok;
            n_next_alive = life_rule(n_win);
            n_row_end    = 1'b0;
            n_frame_end  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= fire && n_has_out;
            end
            if (fire) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_info <= pos_info;
            r_s1_col  <= pos_col;
        end
        if (fire) begin
            r_next_alive <= n_next_alive;
            r_row_end    <= n_row_end;
            r_frame_end  <= n_frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_alive = r_next_alive;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;

endmodule
